// ===== src/mpct_pkg.sv =====
// Package for the mouse packet cursor tracker: field widths, register
// indexes, phase enum and the struct types shared by the modules.
// No dependencies.
package mpct_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  // Sum of a coordinate and a 9-bit signed move, with sign.
  localparam int unsigned SumW = CoordW + 2;

  localparam logic [CfgIdxW-1:0] REG_X_MAX = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_Y_MAX = 2'd1;

  localparam logic [CoordW-1:0] X_MAX_RST = 12'd319;
  localparam logic [CoordW-1:0] Y_MAX_RST = 12'd199;

  // Header byte bit positions.
  localparam int unsigned SYNC_POS  = 3;
  localparam int unsigned XSIGN_POS = 4;
  localparam int unsigned YSIGN_POS = 5;

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_X   = 2'd1,
    PH_Y   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CoordW-1:0] x_max;
    logic [CoordW-1:0] y_max;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] cursor_x;
    logic [CoordW-1:0] cursor_y;
    logic [BtnW-1:0]   button_bits;
    logic              fresh_press;
    logic              left_held;
  } res_t;

endpackage

// ===== src/mpct_if.sv =====
// Valid/ready channel interfaces for mouse bytes and cursor results.
// Depends on mpct_pkg for field widths.
interface mpct_byte_if;
  logic                        valid;
  logic                        ready;
  logic [mpct_pkg::ByteW-1:0]  mouse_byte;

  modport source (output valid, output mouse_byte, input ready);
  modport sink   (input valid, input mouse_byte, output ready);
endinterface

interface mpct_res_if;
  logic                         valid;
  logic                         ready;
  logic [mpct_pkg::CoordW-1:0]  cursor_x;
  logic [mpct_pkg::CoordW-1:0]  cursor_y;
  logic [mpct_pkg::BtnW-1:0]    button_bits;
  logic                         fresh_press;
  logic                         left_held;

  modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                  output fresh_press, output left_held, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
                  input fresh_press, input left_held, output ready);
endinterface

// ===== src/mpct_core.sv =====
// Packet assembly and cursor update: phase, header, X byte, cursor and
// previous-left registers. Depends on mpct_pkg.
module mpct_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [mpct_pkg::ByteW-1:0]  byte_i,
  input  mpct_pkg::cfg_t              cfg_i,
  output logic                        res_vld_o,
  output mpct_pkg::res_t              res_o
);

  mpct_pkg::phase_e            phase_q, phase_d;
  logic [mpct_pkg::ByteW-1:0]  hdr_q, hdr_d;
  logic [mpct_pkg::ByteW-1:0]  xmv_q, xmv_d;
  logic [mpct_pkg::CoordW-1:0] pos_x_q, pos_x_d;
  logic [mpct_pkg::CoordW-1:0] pos_y_q, pos_y_d;
  logic                        prev_left_q, prev_left_d;

  logic signed [mpct_pkg::SumW-1:0] dx, dy, nx, ny;
  logic                             left;

  function automatic logic [mpct_pkg::CoordW-1:0] clamp(
    input logic signed [mpct_pkg::SumW-1:0] v,
    input logic [mpct_pkg::CoordW-1:0]      lim
  );
    logic [mpct_pkg::CoordW-1:0] r;
    if (v[mpct_pkg::SumW-1]) begin
      r = '0;
    end else if (v > $signed({2'b00, lim})) begin
      r = lim;
    end else begin
      r = v[mpct_pkg::CoordW-1:0];
    end
    return r;
  endfunction

  // Sign-extended 9-bit moves: header sign bit on top of the magnitude.
  assign dx = $signed({{(mpct_pkg::SumW-mpct_pkg::ByteW){hdr_q[mpct_pkg::XSIGN_POS]}}, xmv_q});
  assign dy = $signed({{(mpct_pkg::SumW-mpct_pkg::ByteW){hdr_q[mpct_pkg::YSIGN_POS]}}, byte_i});
  assign nx = $signed({2'b00, pos_x_q}) + dx;
  assign ny = $signed({2'b00, pos_y_q}) - dy;
  assign left = hdr_q[0];

  always_comb begin
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    xmv_d       = xmv_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    prev_left_d = prev_left_q;
    res_vld_o   = 1'b0;
    if (step_i) begin
      case (phase_q)
        mpct_pkg::PH_X: begin
          xmv_d   = byte_i;
          phase_d = mpct_pkg::PH_Y;
        end
        mpct_pkg::PH_Y: begin
          pos_x_d     = clamp(nx, cfg_i.x_max);
          pos_y_d     = clamp(ny, cfg_i.y_max);
          prev_left_d = left;
          phase_d     = mpct_pkg::PH_HDR;
          res_vld_o   = 1'b1;
        end
        default: begin
          if (byte_i[mpct_pkg::SYNC_POS]) begin
            hdr_d   = byte_i;
            phase_d = mpct_pkg::PH_X;
          end else begin
            phase_d = mpct_pkg::PH_HDR;
          end
        end
      endcase
    end
  end

  assign res_o.cursor_x    = pos_x_d;
  assign res_o.cursor_y    = pos_y_d;
  assign res_o.button_bits = hdr_q[mpct_pkg::BtnW-1:0];
  assign res_o.fresh_press = left & ~prev_left_q;
  assign res_o.left_held   = left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mpct_pkg::PH_HDR;
      hdr_q       <= '0;
      xmv_q       <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      prev_left_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      xmv_q       <= xmv_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      prev_left_q <= prev_left_d;
    end
  end

`ifndef SYNTH
  a_res_only_on_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> (phase_q == mpct_pkg::PH_Y && step_i))
    else $error("result outside the third byte");
  a_back_to_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |=> (phase_q == mpct_pkg::PH_HDR))
    else $error("phase not reset after packet");
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> (res_o.cursor_x <= cfg_i.x_max && res_o.cursor_y <= cfg_i.y_max))
    else $error("cursor outside limits");
  a_hdr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != mpct_pkg::PH_HDR) |-> hdr_q[mpct_pkg::SYNC_POS])
    else $error("packet open without sync bit");
`endif

endmodule

// ===== src/mpct_out_buf.sv =====
// Two-entry result buffer between the core and the result channel.
// Depends on mpct_pkg for the result struct.
module mpct_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpct_pkg::res_t data_i,
  output logic           full_o,
  output logic           vld_o,
  input  logic           pop_i,
  output mpct_pkg::res_t data_o
);

  mpct_pkg::res_t mem_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign vld_o  = (cnt_q != 2'd0);
  assign full_o = (cnt_q == 2'd2);
  assign pop    = pop_i & vld_o;
  assign data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full buffer");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("buffer count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wptr_q == rptr_q))
    else $error("pointers disagree with count");
`endif

endmodule

// ===== src/mouse_packet_cursor_tracker.sv =====
// Top level of the mouse packet cursor tracker: input byte register,
// limit registers, packet core and result buffer.
// Depends on mpct_pkg, mpct_if, mpct_core and mpct_out_buf.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    mouse_byte[7:0]
//   res_o     out  valid/ready    cursor_x, cursor_y, button_bits,
//                                 fresh_press, left_held
//   cfg_*_i   in   write enable   index 0 x_max, 1 y_max (12 bits)
//
// One byte per cycle while the result buffer is not full; a byte is
// registered on accept and consumed by the core when the buffer has room,
// and a packet's result is written into the result buffer before res_o.
// Reset clears phase, cursor, previous-left and buffer state and loads
// the limits with 319 and 199; no clearing pass.
// When the result side stalls, the two-entry buffer absorbs results and
// in_i.ready drops only once it is full.
module mouse_packet_cursor_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mpct_byte_if.sink                     in_i,
  mpct_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [mpct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpct_pkg::CfgDataW-1:0] cfg_wdata_i
);

  // Limit registers; writes to unused indexes are ignored.
  mpct_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mpct_pkg::REG_X_MAX: cfg_d.x_max = cfg_wdata_i[mpct_pkg::CoordW-1:0];
        mpct_pkg::REG_Y_MAX: cfg_d.y_max = cfg_wdata_i[mpct_pkg::CoordW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_max <= mpct_pkg::X_MAX_RST;
      cfg_q.y_max <= mpct_pkg::Y_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register stage.
  logic                       in_vld_q, in_vld_d;
  logic [mpct_pkg::ByteW-1:0] in_byte_q;
  logic                       advance;
  logic                       buf_full;
  logic                       in_acc;

  assign advance    = in_vld_q & ~buf_full;
  assign in_i.ready = ~in_vld_q | advance;
  assign in_acc     = in_i.valid & in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.mouse_byte;
    end
  end

  // Packet core: consumes the registered byte when the buffer has room.
  logic           core_vld;
  mpct_pkg::res_t core_res;

  mpct_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .cfg_i     (cfg_q),
    .res_vld_o (core_vld),
    .res_o     (core_res)
  );

  // Result buffer toward the output channel.
  mpct_pkg::res_t buf_res;

  mpct_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (core_vld),
    .data_i (core_res),
    .full_o (buf_full),
    .vld_o  (res_o.valid),
    .pop_i  (res_o.ready),
    .data_o (buf_res)
  );

  assign res_o.cursor_x    = buf_res.cursor_x;
  assign res_o.cursor_y    = buf_res.cursor_y;
  assign res_o.button_bits = buf_res.button_bits;
  assign res_o.fresh_press = buf_res.fresh_press;
  assign res_o.left_held   = buf_res.left_held;

endmodule
